// ----- hw/rtl/tcsm_pkg.sv -----
// Shared types and constants for the tick-count to seconds/microseconds block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package tcsm_pkg;

   localparam int TICK_W  = 32;
   localparam int SUB_W   = 16;
   localparam int SHIFT_W = 3;
   localparam int CLK_W   = 24;
   localparam int SEC_W   = 32;
   localparam int US_W    = 20;
   localparam int LEFT_W  = 7;
   localparam int PROD_W  = 36;   // subtick * 1e6 fits in 36 bits
   localparam int QUO_W   = 32;   // sub-tick microseconds keep their low 32 bits
   localparam int SUM_W   = 32;
   localparam int SEC_Q_W = 13;   // (2^32 - 1) / 1e6 < 2^13

   // floor(x / 1e6) == (x * US_RECIP) >> RECIP_SHIFT for every 32-bit x
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 50;
   localparam logic [RECIP_W-1:0] US_RECIP = RECIP_W'(1125899907);

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_CONFIGURED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE_LOG2   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_CLOCK_HZ  = CSR_IDX_W'(2);

   localparam logic [CLK_W-1:0] SOURCE_HZ_RESET = CLK_W'(32768);
   localparam logic [US_W-1:0]  ONE_SECOND_US   = US_W'(1000000);

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic               clock_configured;
      logic [SHIFT_W-1:0] tick_rate_log2;
      logic [CLK_W-1:0]   source_clock_hz;
   } cfg_type;

   // One item on its way through the sub-tick divider.
   typedef struct packed {
      logic              configured;
      logic [SEC_W-1:0]  secs;
      logic [US_W-1:0]   us_ticks;
      logic [PROD_W-1:0] prod;
      logic [QUO_W-1:0]  quo;
      logic [CLK_W-1:0]  rem;
   } div_stage_type;

   // One item on its way through the divide by one million.
   typedef struct packed {
      logic               configured;
      logic [SEC_W-1:0]   secs;
      logic [SUM_W-1:0]   val;
      logic [SEC_Q_W-1:0] quo;
   } cdiv_stage_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tcsm_ifs.sv -----
// Handshake channels of the tick-count converter: request, response, CSR write.
// Depends on tcsm_pkg for field widths.
`default_nettype none

interface tcsm_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcsm_pkg::TICK_W-1:0]  tick_count;
   logic [tcsm_pkg::SUB_W-1:0]   subtick_count;
   modport source (output valid, tick_count, subtick_count, input ready);
   modport sink   (input valid, tick_count, subtick_count, output ready);
endinterface

interface tcsm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcsm_pkg::SEC_W-1:0]   seconds;
   logic [tcsm_pkg::US_W-1:0]    microseconds;
   modport source (output valid, seconds, microseconds, input ready);
   modport sink   (input valid, seconds, microseconds, output ready);
endinterface

interface tcsm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tcsm_pkg::CSR_IDX_W-1:0]  index;
   logic [tcsm_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcsm_csr.sv -----
// Configuration registers of the tick-count converter.
// Depends on tcsm_pkg and tcsm_csr_if.
`default_nettype none

module tcsm_csr (
   input  wire               clock,
   input  wire               reset,
   tcsm_csr_if.sink          csr_bus,
   output tcsm_pkg::cfg_type cfg
);

   tcsm_pkg::cfg_type cfg_ff;
   tcsm_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tcsm_pkg::CSR_CLOCK_CONFIGURED:
               cfg_in.clock_configured = csr_bus.data[0];
            tcsm_pkg::CSR_TICK_RATE_LOG2:
               cfg_in.tick_rate_log2 = csr_bus.data[tcsm_pkg::SHIFT_W-1:0];
            tcsm_pkg::CSR_SOURCE_CLOCK_HZ:
               cfg_in.source_clock_hz = csr_bus.data[tcsm_pkg::CLK_W-1:0];
            default: ;   // drop writes to unknown registers
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_configured <= 1'b0;
         cfg_ff.tick_rate_log2   <= '0;
         cfg_ff.source_clock_hz  <= tcsm_pkg::SOURCE_HZ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tcsm_front.sv -----
// Request side: accepts readings, splits whole seconds from leftover ticks and
// forms both microsecond products. Depends on tcsm_pkg and tcsm_req_if.
`default_nettype none

module tcsm_front (
   tcsm_req_if.sink                 req_bus,
   input  tcsm_pkg::cfg_type        cfg,
   input  wire                      queue_full,
   output logic                     push,
   output tcsm_pkg::div_stage_type  push_entry
);

   logic [tcsm_pkg::LEFT_W-1:0]         left_mask;
   logic [tcsm_pkg::LEFT_W-1:0]         left;
   logic [tcsm_pkg::LEFT_W+tcsm_pkg::US_W-1:0] left_us;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      left_mask = tcsm_pkg::LEFT_W'(((tcsm_pkg::LEFT_W+1)'(1) << cfg.tick_rate_log2)
                                    - (tcsm_pkg::LEFT_W+1)'(1));
      left      = req_bus.tick_count[tcsm_pkg::LEFT_W-1:0] & left_mask;
      left_us   = (tcsm_pkg::LEFT_W+tcsm_pkg::US_W)'(left) *
                  (tcsm_pkg::LEFT_W+tcsm_pkg::US_W)'(tcsm_pkg::ONE_SECOND_US);

      push_entry.configured = cfg.clock_configured;
      push_entry.secs       = req_bus.tick_count >> cfg.tick_rate_log2;
      push_entry.us_ticks   = tcsm_pkg::US_W'(left_us >> cfg.tick_rate_log2);
      push_entry.prod       = tcsm_pkg::PROD_W'(req_bus.subtick_count) *
                              tcsm_pkg::PROD_W'(tcsm_pkg::ONE_SECOND_US);
      push_entry.quo        = '0;
      push_entry.rem        = '0;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tcsm_queue.sv -----
// Short FIFO between the request side and the divider pipeline.
// Depends on tcsm_pkg.
`default_nettype none

module tcsm_queue #(
   parameter int DEPTH = tcsm_pkg::QUEUE_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  tcsm_pkg::div_stage_type  push_entry,
   output logic                     full,
   input  wire                      pop,
   output logic                     head_valid,
   output tcsm_pkg::div_stage_type  head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   tcsm_pkg::div_stage_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tcsm_back.sv -----
// Back pipeline: bit-per-stage divide of the sub-tick product by the source
// clock, microsecond sum, reciprocal divide by one million, carry into seconds.
// Depends on tcsm_pkg and tcsm_rsp_if.
`default_nettype none

module tcsm_back (
   input  wire                      clock,
   input  wire                      reset,
   input  tcsm_pkg::cfg_type        cfg,
   input  wire                      head_valid,
   input  tcsm_pkg::div_stage_type  head_entry,
   output logic                     pop,
   tcsm_rsp_if.source               rsp_bus
);

   localparam int NDIV   = tcsm_pkg::PROD_W;
   localparam int CLK_W  = tcsm_pkg::CLK_W;
   localparam int RPROD_W = tcsm_pkg::SUM_W + tcsm_pkg::RECIP_W;

   logic                    adv;
   logic [CLK_W-1:0]        clk_eff;

   tcsm_pkg::div_stage_type  div_ff       [NDIV];
   logic                     div_valid_ff [NDIV];
   tcsm_pkg::cdiv_stage_type sum_ff;
   logic                     sum_valid_ff;
   tcsm_pkg::cdiv_stage_type rcp_ff, rcp_in;
   logic                     rcp_valid_ff;
   logic [RPROD_W-1:0]       rcp_prod;
   logic [tcsm_pkg::US_W-1:0] whole_us;

   logic                      out_valid_ff;
   logic [tcsm_pkg::SEC_W-1:0] seconds_ff, seconds_in;
   logic [tcsm_pkg::US_W-1:0]  micro_ff, micro_in;

   // The whole pipeline moves together; it halts only when the result is held.
   assign adv     = !out_valid_ff || rsp_bus.ready;
   assign pop     = adv && head_valid;
   assign clk_eff = (cfg.source_clock_hz == '0) ? CLK_W'(1) : cfg.source_clock_hz;

   for (genvar i = 0; i < NDIV; i++) begin : g_div
      tcsm_pkg::div_stage_type cur, nxt;
      logic                    cur_valid;
      logic [CLK_W:0]          partial, diff;
      logic                    ge;

      if (i == 0) begin : g_first
         assign cur       = head_entry;
         assign cur_valid = head_valid;
      end else begin : g_next
         assign cur       = div_ff[i-1];
         assign cur_valid = div_valid_ff[i-1];
      end

      always_comb begin
         partial = {cur.rem, cur.prod[NDIV-1-i]};
         diff    = partial - {1'b0, clk_eff};
         ge      = (partial >= {1'b0, clk_eff});
         nxt     = cur;
         nxt.rem = ge ? diff[CLK_W-1:0] : partial[CLK_W-1:0];
         nxt.quo = {cur.quo[tcsm_pkg::QUO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            div_valid_ff[i] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[i] <= nxt;
         end
      end
   end

   // Add both microsecond parts, wrapping at 32 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         sum_valid_ff <= div_valid_ff[NDIV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff.configured <= div_ff[NDIV-1].configured;
         sum_ff.secs       <= div_ff[NDIV-1].secs;
         sum_ff.val        <= tcsm_pkg::SUM_W'(div_ff[NDIV-1].us_ticks) +
                              div_ff[NDIV-1].quo;
         sum_ff.quo        <= '0;
      end
   end

   // Whole seconds of the sum through the reciprocal of one million.
   always_comb begin
      rcp_prod   = RPROD_W'(sum_ff.val) * RPROD_W'(tcsm_pkg::US_RECIP);
      rcp_in     = sum_ff;
      rcp_in.quo = rcp_prod[tcsm_pkg::RECIP_SHIFT +: tcsm_pkg::SEC_Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcp_valid_ff <= 1'b0;
      end else if (adv) begin
         rcp_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rcp_ff <= rcp_in;
      end
   end

   // The remainder is below 2^20, so the low 20 bits of the subtraction suffice.
   always_comb begin
      whole_us = tcsm_pkg::US_W'(rcp_ff.quo) * tcsm_pkg::ONE_SECOND_US;
      if (rcp_ff.configured) begin
         seconds_in = rcp_ff.secs + tcsm_pkg::SEC_W'(rcp_ff.quo);
         micro_in   = rcp_ff.val[tcsm_pkg::US_W-1:0] - whole_us;
      end else begin
         seconds_in = '0;
         micro_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= rcp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seconds_ff <= seconds_in;
         micro_ff   <= micro_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.seconds      = seconds_ff;
   assign rsp_bus.microseconds = micro_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tick_count_to_seconds_micros.sv -----
// Real-time-clock reading to seconds/microseconds timestamp converter. One
// reading (whole tick count, sub-tick counter value) is accepted per cycle
// while the input queue is not full, and one timestamp is returned per
// reading, in order. An accepted request passes through the input queue, the
// bit-per-stage divider that scales the sub-tick counter by the source clock,
// the microsecond sum register and the reciprocal divide by one million,
// after which the output register holds the response. When the response side
// stalls, the whole back pipeline holds and the input queue keeps taking
// requests until it fills. Write the CSRs only while no request is in flight;
// while the clock is not configured every timestamp reads as zero.
`default_nettype none

module tick_count_to_seconds_micros #(
   parameter int QUEUE_DEPTH = tcsm_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   tcsm_req_if.sink    req_bus,
   tcsm_rsp_if.source  rsp_bus,
   tcsm_csr_if.sink    csr_bus
);

   tcsm_pkg::cfg_type       cfg;
   tcsm_pkg::div_stage_type push_entry;
   tcsm_pkg::div_stage_type head_entry;
   logic                    push;
   logic                    queue_full;
   logic                    pop;
   logic                    head_valid;

   tcsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tcsm_front u_front (
      .req_bus    (req_bus),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   tcsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tcsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
